/* rtl/ptpp_pkg.sv */
// shared types and constants of the period timer with prescaler and postscaler
// no dependencies; used by the core and its bench
package ptpp_pkg;

  // request kinds on the input stream
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // register addresses
  localparam logic [2:0] ADDR_CNT_LO = 3'd0;
  localparam logic [2:0] ADDR_CNT_HI = 3'd1;
  localparam logic [2:0] ADDR_CTRL0  = 3'd2;
  localparam logic [2:0] ADDR_CTRL1  = 3'd3;

  // clock select codes
  localparam logic [2:0] CLKSEL_FOSC4 = 3'd2;
  localparam logic [2:0] CLKSEL_HFINT = 3'd3;
  localparam logic [2:0] CLKSEL_LFINT = 3'd4;
  localparam logic [2:0] CLKSEL_MFINT = 3'd5;

  // control0 bit positions
  localparam int unsigned CTRL0_EN_BIT   = 7;
  localparam int unsigned CTRL0_OUT_BIT  = 5;
  localparam int unsigned CTRL0_WIDE_BIT = 4;

  // register reset values
  localparam logic [7:0] PERIOD_RST = 8'hFF;

  // remainder sequencer steps, one per dividend bit
  localparam int unsigned DIV_STEPS = 16;

  // field widths
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PRE_W  = 15;
  localparam int unsigned POST_W = 4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MOD
  } state_e;

endpackage

/* rtl/period_timer_prescale_postscale_core.sv */
// Result: each request gives its result in the output register in the cycle after acceptance.
// Throughput: ticks, reads and non-reloading writes are taken one per cycle while the output
// is not stalled; a reloading write in 8-bit mode runs a shared restoring remainder unit, one
// dividend bit a cycle, and no further request is taken until that unit has finished.
// Reset: rst_ni is asynchronous, active low; state registers reset at once, payloads do not.
// Depends on ptpp_pkg.
module period_timer_prescale_postscale_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] wdata, [11:8] source_pulses, [15:12] zero
  input  logic [4:0]  s_axis_tuser,   // [1:0] mode, [4:2] addr
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] rdata, [8] irq_pulse, [9] out_level, [15:10] zero
);

  // architectural registers
  logic [15:0] counter_q, counter_d;
  logic [7:0]  period_q, period_d;
  logic [7:0]  hbuf_q, hbuf_d;
  logic [7:0]  ctrl0_q, ctrl0_d;
  logic [7:0]  ctrl1_q, ctrl1_d;
  logic [3:0]  post_q, post_d;
  logic        tog_q, tog_d;
  logic [14:0] pre_q, pre_d;

  // remainder unit
  ptpp_pkg::state_e state_q, state_d;
  logic [15:0] num_q, num_d;
  logic [7:0]  rem_q, rem_d;
  logic [8:0]  den_q, den_d;
  logic [3:0]  step_q, step_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [7:0]  ordata_q, ordata_d;
  logic        oirq_q, oirq_d;

  // request fields
  logic [1:0]  in_mode;
  logic [2:0]  in_addr;
  logic [7:0]  in_wdata;
  logic [3:0]  in_pulses;
  logic        accept;

  // tick datapath
  logic        wide;
  logic        src_hit;
  logic [15:0] pre_inc;
  logic [15:0] scale;
  logic [16:0] cnt_inc;
  logic [16:0] wrap_len;
  logic [4:0]  post_inc;

  // reload helpers
  logic        do_reload;
  logic        reload_wide;
  logic [15:0] reload_val;
  logic [8:0]  reload_den;
  logic [8:0]  trial;

  assign in_mode   = s_axis_tuser[1:0];
  assign in_addr   = s_axis_tuser[4:2];
  assign in_wdata  = s_axis_tdata[7:0];
  assign in_pulses = s_axis_tdata[11:8];

  assign s_axis_tready = (state_q == ptpp_pkg::ST_IDLE) && (!ovalid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'b0, tog_q, oirq_q, ordata_q};

  // tick arithmetic
  assign wide     = ctrl0_q[ptpp_pkg::CTRL0_WIDE_BIT];
  assign pre_inc  = {1'b0, pre_q} + 16'd1;
  assign scale    = 16'd1 << ctrl1_q[3:0];
  assign cnt_inc  = {1'b0, counter_q} + 17'd1;
  assign wrap_len = wide ? 17'h10000 : ({9'b0, period_q} + 17'd1);
  assign post_inc = {1'b0, post_q} + 5'd1;

  // selected clock source
  always_comb begin
    unique case (ctrl1_q[7:5])
      ptpp_pkg::CLKSEL_FOSC4: src_hit = in_pulses[0];
      ptpp_pkg::CLKSEL_HFINT: src_hit = in_pulses[1];
      ptpp_pkg::CLKSEL_LFINT: src_hit = in_pulses[2];
      ptpp_pkg::CLKSEL_MFINT: src_hit = in_pulses[3];
      default:                src_hit = 1'b0;
    endcase
  end

  // one remainder step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, num_q[15]};

  // sequencer, register updates and result
  always_comb begin
    state_d   = state_q;
    counter_d = counter_q;
    period_d  = period_q;
    hbuf_d    = hbuf_q;
    ctrl0_d   = ctrl0_q;
    ctrl1_d   = ctrl1_q;
    post_d    = post_q;
    tog_d     = tog_q;
    pre_d     = pre_q;
    num_d     = num_q;
    rem_d     = rem_q;
    den_d     = den_q;
    step_d    = step_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ordata_d  = ordata_q;
    oirq_d    = oirq_q;

    do_reload   = 1'b0;
    reload_wide = wide;
    reload_val  = counter_q;
    reload_den  = {1'b0, period_q} + 9'd1;

    unique case (state_q)
      ptpp_pkg::ST_IDLE: begin
        if (accept) begin
          ovalid_d = 1'b1;
          ordata_d = 8'd0;
          oirq_d   = 1'b0;
          case (in_mode)
            ptpp_pkg::MODE_TICK: begin
              if (ctrl0_q[ptpp_pkg::CTRL0_EN_BIT] && src_hit) begin
                if (pre_inc >= scale) begin
                  pre_d = '0;
                  if (cnt_inc >= wrap_len) begin
                    counter_d = '0;
                    if (post_inc <= {1'b0, ctrl0_q[3:0]}) begin
                      post_d = post_inc[3:0];
                    end else begin
                      post_d = '0;
                      tog_d  = !tog_q;
                      oirq_d = 1'b1;
                    end
                  end else begin
                    counter_d = cnt_inc[15:0];
                  end
                end else begin
                  pre_d = pre_inc[14:0];
                end
              end
            end
            ptpp_pkg::MODE_READ: begin
              unique case (in_addr)
                ptpp_pkg::ADDR_CNT_LO: begin
                  ordata_d = counter_q[7:0];
                  if (wide) hbuf_d = counter_q[15:8];
                end
                ptpp_pkg::ADDR_CNT_HI: ordata_d = wide ? hbuf_q : period_q;
                ptpp_pkg::ADDR_CTRL0:  ordata_d = {ctrl0_q[7:6], tog_q, ctrl0_q[4:0]};
                ptpp_pkg::ADDR_CTRL1:  ordata_d = ctrl1_q;
                default:               ordata_d = 8'd0;
              endcase
            end
            ptpp_pkg::MODE_WRITE: begin
              unique case (in_addr)
                ptpp_pkg::ADDR_CNT_LO: begin
                  do_reload  = 1'b1;
                  reload_val = wide ? {hbuf_q, in_wdata} : {8'd0, in_wdata};
                end
                ptpp_pkg::ADDR_CNT_HI: begin
                  if (wide) begin
                    hbuf_d = in_wdata;
                  end else begin
                    period_d   = in_wdata;
                    do_reload  = 1'b1;
                    reload_den = {1'b0, in_wdata} + 9'd1;
                  end
                end
                ptpp_pkg::ADDR_CTRL0: begin
                  ctrl0_d     = in_wdata & ~(8'd1 << ptpp_pkg::CTRL0_OUT_BIT);
                  do_reload   = 1'b1;
                  reload_wide = in_wdata[ptpp_pkg::CTRL0_WIDE_BIT];
                end
                ptpp_pkg::ADDR_CTRL1: begin
                  ctrl1_d   = in_wdata;
                  do_reload = 1'b1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase

          // reload: clear prescaler and reduce the count modulo the period
          if (do_reload) begin
            pre_d = '0;
            if (reload_wide) begin
              counter_d = reload_val;
            end else begin
              num_d   = reload_val;
              rem_d   = '0;
              den_d   = reload_den;
              step_d  = '0;
              state_d = ptpp_pkg::ST_MOD;
            end
          end
        end
      end
      ptpp_pkg::ST_MOD: begin
        num_d = {num_q[14:0], 1'b0};
        if (trial >= den_q) rem_d = 8'(trial - den_q);
        else                rem_d = trial[7:0];
        step_d = step_q + 4'd1;
        if (step_q == 4'(ptpp_pkg::DIV_STEPS - 1)) begin
          counter_d = {8'd0, rem_d};
          state_d   = ptpp_pkg::ST_IDLE;
        end
      end
      default: state_d = ptpp_pkg::ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptpp_pkg::ST_IDLE;
      counter_q <= '0;
      period_q  <= ptpp_pkg::PERIOD_RST;
      hbuf_q    <= '0;
      ctrl0_q   <= '0;
      ctrl1_q   <= '0;
      post_q    <= '0;
      tog_q     <= 1'b0;
      pre_q     <= '0;
      ovalid_q  <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      period_q  <= period_d;
      hbuf_q    <= hbuf_d;
      ctrl0_q   <= ctrl0_d;
      ctrl1_q   <= ctrl1_d;
      post_q    <= post_d;
      tog_q     <= tog_d;
      pre_q     <= pre_d;
      ovalid_q  <= ovalid_d;
      step_q    <= step_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    ordata_q <= ordata_d;
    oirq_q   <= oirq_d;
  end

endmodule

/* rtl/ptpp_checker.sv */
// port-level checker for the period timer core, attached by bind
// depends on the core's port list
module ptpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // every accepted request shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after accepted request");

  // an interrupt only comes from a tick, which reads no data
  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("interrupt result carries read data");

  // a stalled result stays valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind period_timer_prescale_postscale_core ptpp_checker u_ptpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_period_timer_prescale_postscale_core.sv */
// self-checking bench for period_timer_prescale_postscale_core: directed table, random episodes
// every accepted request is predicted by a local timer model and checked at the response stream
// depends on ptpp_pkg and the core rtl
module tb_period_timer_prescale_postscale_core;

  timeunit 1ns;
  timeprecision 1ps;

  // request kind that the core ignores, spare register addresses
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [2:0] ADDR_SPARE = 3'd5;
  localparam logic [2:0] ADDR_TOP   = 3'd7;

  localparam int unsigned RANDOM_REQS = 700;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 24;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic [3:0] pulses;
  } timer_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       level;
  } timer_resp_t;

  typedef struct {
    logic [1:0] mode;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic [3:0] pulses;
    bit         typed;
    logic [7:0] rdata;
    logic       irq;
    logic       level;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] wdata, [11:8] source_pulses, [15:12] zero
  logic [4:0]  s_axis_tuser;   // [1:0] mode, [4:2] addr
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] rdata, [8] irq_pulse, [9] out_level, [15:10] zero

  period_timer_prescale_postscale_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // timer state as the predictor sees it
  logic [31:0] tmr_count;
  logic [31:0] tmr_prediv;
  logic [7:0]  tmr_period;
  logic [7:0]  tmr_hold_hi;
  logic [7:0]  tmr_ctrl0;
  logic [7:0]  tmr_ctrl1;
  logic [3:0]  tmr_post;
  logic        tmr_level;

  timer_resp_t pending_responses[$];

  int n_reqs;
  int n_resps;
  int n_irqs;
  int n_reads;
  int n_errors;
  int burst_left;
  bit pace_free;
  bit hold_done;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] count_span();
    return tmr_ctrl0[ptpp_pkg::CTRL0_WIDE_BIT] ? 32'h10000 : {24'd0, tmr_period} + 32'd1;
  endfunction

  // count reduced modulo the period, prescaler cleared
  function automatic void reload_count(logic [31:0] value);
    tmr_count  = value % count_span();
    tmr_prediv = '0;
  endfunction

  function automatic void reset_timer_model();
    tmr_period  = ptpp_pkg::PERIOD_RST;
    tmr_hold_hi = '0;
    tmr_ctrl0   = '0;
    tmr_ctrl1   = '0;
    tmr_post    = '0;
    tmr_level   = 1'b0;
    reload_count('0);
  endfunction

  // advance the timer model by one request and return its response
  function automatic timer_resp_t predict_timer_response(timer_req_t r);
    timer_resp_t rsp;
    logic        wide;
    logic        pulsed;
    logic [2:0]  sel;
    logic [31:0] next_post;
    rsp    = '0;
    wide   = tmr_ctrl0[ptpp_pkg::CTRL0_WIDE_BIT];
    sel    = tmr_ctrl1[7:5];
    pulsed = 1'b0;
    case (r.mode)
      ptpp_pkg::MODE_TICK: begin
        if (sel >= ptpp_pkg::CLKSEL_FOSC4 && sel <= ptpp_pkg::CLKSEL_MFINT) begin
          pulsed = r.pulses[sel - ptpp_pkg::CLKSEL_FOSC4];
        end
        if (tmr_ctrl0[ptpp_pkg::CTRL0_EN_BIT] && pulsed) begin
          tmr_prediv = tmr_prediv + 1;
          if (tmr_prediv >= (32'd1 << tmr_ctrl1[3:0])) begin
            tmr_prediv = '0;
            tmr_count  = tmr_count + 1;
            if (tmr_count >= count_span()) begin
              tmr_count = '0;
              next_post = {28'd0, tmr_post} + 1;
              if (next_post < {28'd0, tmr_ctrl0[3:0]} + 1) begin
                tmr_post = next_post[3:0];
              end else begin
                tmr_post  = '0;
                tmr_level = ~tmr_level;
                rsp.irq   = 1'b1;
              end
            end
          end
        end
      end
      ptpp_pkg::MODE_READ: begin
        case (r.addr)
          ptpp_pkg::ADDR_CNT_LO: begin
            if (wide) tmr_hold_hi = tmr_count[15:8];
            rsp.rdata = tmr_count[7:0];
          end
          ptpp_pkg::ADDR_CNT_HI: rsp.rdata = wide ? tmr_hold_hi : tmr_period;
          ptpp_pkg::ADDR_CTRL0: begin
            rsp.rdata = tmr_ctrl0;
            rsp.rdata[ptpp_pkg::CTRL0_OUT_BIT] = tmr_level;
          end
          ptpp_pkg::ADDR_CTRL1: rsp.rdata = tmr_ctrl1;
          default: rsp.rdata = '0;
        endcase
      end
      ptpp_pkg::MODE_WRITE: begin
        case (r.addr)
          ptpp_pkg::ADDR_CNT_LO: begin
            reload_count(wide ? {16'd0, tmr_hold_hi, r.wdata} : {24'd0, r.wdata});
          end
          ptpp_pkg::ADDR_CNT_HI: begin
            if (wide) begin
              tmr_hold_hi = r.wdata;
            end else begin
              tmr_period = r.wdata;
              reload_count(tmr_count);
            end
          end
          ptpp_pkg::ADDR_CTRL0: begin
            tmr_ctrl0 = r.wdata;
            tmr_ctrl0[ptpp_pkg::CTRL0_OUT_BIT] = 1'b0;
            reload_count(tmr_count);
          end
          ptpp_pkg::ADDR_CTRL1: begin
            tmr_ctrl1 = r.wdata;
            reload_count(tmr_count);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.level = tmr_level;
    return rsp;
  endfunction

  // offer one request in bursts with random gaps, predict it once taken
  task automatic send_request(timer_req_t r, bit typed, timer_resp_t want);
    int          gap;
    timer_resp_t rsp;
    if (burst_left == 0) begin
      gap        = pace_free ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, r.pulses, r.wdata};
    s_axis_tuser  <= {r.addr, r.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    rsp = predict_timer_response(r);
    pending_responses.push_back(typed ? want : rsp);
    if (r.mode == ptpp_pkg::MODE_READ) n_reads++;
    n_reqs++;
    burst_left--;
  endtask

  task automatic send_checked(logic [1:0] mode, logic [2:0] addr, logic [7:0] wdata,
                              logic [3:0] pulses);
    send_request('{mode, addr, wdata, pulses}, 1'b0, '0);
  endtask

  // sender stops until every response is back
  task automatic drain_responses();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    burst_left = 0;
  endtask

  // one well-formed setup of the timer followed by a stream of mostly ticks
  task automatic random_episode();
    logic [2:0] sel;
    logic [3:0] pre;
    logic [3:0] post;
    logic       wide;
    logic       en;
    logic [3:0] pulses;
    int         n_items;
    int         pick;
    sel  = ($urandom_range(0, 99) < 85)
           ? 3'($urandom_range(ptpp_pkg::CLKSEL_FOSC4, ptpp_pkg::CLKSEL_MFINT))
           : 3'($urandom_range(0, 7));
    pre  = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
    post = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    wide = ($urandom_range(0, 99) < 20);
    en   = ($urandom_range(0, 99) < 90);
    send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL1,
                 {sel, 1'($urandom_range(0, 1)), pre}, 4'($urandom));
    if (!wide) begin
      send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_HI,
                   ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 5)) : 8'($urandom),
                   4'($urandom));
    end
    send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL0,
                 {en, 2'($urandom_range(0, 3)), wide, post}, 4'($urandom));
    if (wide) begin
      // park the count close to the top so that it wraps soon
      send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_HI,
                   ($urandom_range(0, 99) < 85) ? 8'hFF : 8'($urandom), 4'($urandom));
      send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_LO,
                   8'($urandom_range(8'hE0, 8'hFF)), 4'($urandom));
    end
    n_items = $urandom_range(15, 40);
    repeat (n_items) begin
      pick   = $urandom_range(0, 99);
      pulses = 4'($urandom);
      if (sel >= ptpp_pkg::CLKSEL_FOSC4 && sel <= ptpp_pkg::CLKSEL_MFINT &&
          $urandom_range(0, 99) < 80) begin
        pulses[sel - ptpp_pkg::CLKSEL_FOSC4] = 1'b1;
      end
      if (pick < 8) begin
        send_checked(ptpp_pkg::MODE_READ,
                     ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3)) : 3'($urandom),
                     8'($urandom), pulses);
      end else if (pick < 13) begin
        send_checked(2'($urandom), 3'($urandom), 8'($urandom), 4'($urandom));
      end else if (pick < 15) begin
        // shrink the postscale under the running count
        send_checked(ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL0,
                     {en, 2'($urandom_range(0, 3)), wide, 4'd0}, pulses);
      end else begin
        send_checked(ptpp_pkg::MODE_TICK, 3'($urandom), 8'($urandom), pulses);
      end
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    timer_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_resps++;
      if (m_axis_tdata[8]) n_irqs++;
      if (pending_responses.size() == 0) begin
        $error("unexpected response: tdata %04h with nothing pending", m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_responses.pop_front();
        if (m_axis_tdata[7:0] !== want.rdata) begin
          $error("rdata mismatch: expected %02h, got %02h", want.rdata, m_axis_tdata[7:0]);
          n_errors++;
        end
        if (m_axis_tdata[8] !== want.irq) begin
          $error("irq_pulse mismatch: expected %0b, got %0b", want.irq, m_axis_tdata[8]);
          n_errors++;
        end
        if (m_axis_tdata[9] !== want.level) begin
          $error("out_level mismatch: expected %0b, got %0b", want.level, m_axis_tdata[9]);
          n_errors++;
        end
      end
    end
  end

  // response side stalls: random, fully open stretches, one long hold-off
  initial begin
    int hold_left;
    int rx_phase;
    hold_left = 0;
    rx_phase  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_resps >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_phase[6]) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      rx_phase++;
    end
  end

  // watchdog
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

  // directed table, random episodes, final report
  initial begin
    stim_row_t rows[$];
    int        guard;
    int        start_reqs;
    n_reqs        = 0;
    n_resps       = 0;
    n_irqs        = 0;
    n_reads       = 0;
    n_errors      = 0;
    burst_left    = 0;
    pace_free     = 1'b0;
    hold_done     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    reset_timer_model();

    // registers after reset, spare addresses and the ignored kind
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h0,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CNT_HI, 8'h00, 4'h0,
                     1'b1, 8'hFF, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CTRL0, 8'h00, 4'h0,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CTRL1, 8'h00, 4'h0,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ADDR_TOP, 8'hFF, 4'hF,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ADDR_TOP, 8'hFF, 4'hF,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{MODE_NONE, ptpp_pkg::ADDR_CTRL0, 8'hFF, 4'hF,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ADDR_SPARE, 8'hFF, 4'hF,
                     1'b1, 8'h00, 1'b0, 1'b0});
    // fosc/4, no prescale, period zero, enabled with a postscale of two
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL1,
                     {ptpp_pkg::CLKSEL_FOSC4, 5'd0}, 4'h0, 1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_HI, 8'h00, 4'h0,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL0, 8'hA1, 4'h0,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CTRL0, 8'h00, 4'h0,
                     1'b1, 8'h81, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h1,
                     1'b1, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h1,
                     1'b1, 8'h00, 1'b1, 1'b1});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CTRL0, 8'h00, 4'h0,
                     1'b1, 8'hA1, 1'b0, 1'b1});
    // pulse on an unselected source, then no valid source at all
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'hE,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL1, 8'hFF, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CTRL1, 8'h00, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'hF,
                     1'b0, 8'h00, 1'b0, 1'b0});
    // 16-bit mode, mfintosc, count loaded just below the top
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL0, 8'h9F, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL1,
                     {ptpp_pkg::CLKSEL_MFINT, 1'b1, 4'd0}, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_HI, 8'hFF, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_LO, 8'hFE, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h8,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h8,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_READ, ptpp_pkg::ADDR_CNT_HI, 8'h00, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    // postscale dropped under the running postscaler, back to 8-bit
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CTRL0, 8'h80, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_TICK, ptpp_pkg::ADDR_CNT_LO, 8'h00, 4'h8,
                     1'b0, 8'h00, 1'b0, 1'b0});
    rows.push_back('{ptpp_pkg::MODE_WRITE, ptpp_pkg::ADDR_CNT_HI, 8'hFF, 4'h0,
                     1'b0, 8'h00, 1'b0, 1'b0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      send_request('{rows[i].mode, rows[i].addr, rows[i].wdata, rows[i].pulses},
                   rows[i].typed, '{rows[i].rdata, rows[i].irq, rows[i].level});
    end
    drain_responses();

    // random episodes, now and then with the sender drained
    start_reqs = n_reqs;
    while (n_reqs - start_reqs < RANDOM_REQS) begin
      pace_free = ($urandom_range(0, 3) == 0);
      random_episode();
      if ($urandom_range(0, 5) == 0) drain_responses();
    end

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    guard = pending_responses.size();
    if (guard != 0) begin
      $error("%0d responses never arrived", guard);
      n_errors += guard;
    end

    $display("covered %0d requests (%0d reads), %0d responses, %0d interrupt pulses",
             n_reqs, n_reads, n_resps, n_irqs);
    $display("with random stalls on both sides and one long response hold-off");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ptpp_pkg.sv
rtl/period_timer_prescale_postscale_core.sv
rtl/ptpp_checker.sv
bench/tb_period_timer_prescale_postscale_core.sv
